// ----- design/rsp_pkg.sv -----
`timescale 1ns / 1ps
// rsp_pkg: shared types, codes and constants for the random slice replica placer
// used by rsp_hash, rsp_table and random_slice_replica_placer; depends on nothing

package rsp_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PLACE = 1'b1;

  localparam logic REG_COPIES         = 1'b0;
  localparam logic REG_INTERVAL_COUNT = 1'b1;

  localparam int KEY_W   = 64;
  localparam int POS_W   = 56;
  localparam int SLOT_W  = 6;
  localparam int OWNER_W = 16;
  localparam int CFG_W   = 7;
  localparam int COUNT_W = 7;
  localparam int RETRY_W = 8;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT = 8'd200;
  localparam logic [2:0]         MIX_LAST    = 3'd6;

  typedef struct packed {
    logic             load;
    logic [KEY_W-1:0] seed;
  } hash_ctl_t;

  typedef struct packed {
    logic               start;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } scan_ctl_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [KEY_W-1:0]   start;
    logic [OWNER_W-1:0] owner;
  } tbl_wr_t;

  // one round of the 64-bit integer mix, logical shifts
  function automatic logic [KEY_W-1:0] mix_step(input logic [2:0] step,
                                                input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] r;
    unique case (step)
      3'd0:    r = ~k + (k << 21);
      3'd1:    r = k ^ (k >> 24);
      3'd2:    r = k + (k << 3) + (k << 8);
      3'd3:    r = k ^ (k >> 14);
      3'd4:    r = k + (k << 2) + (k << 4);
      3'd5:    r = k ^ (k >> 28);
      3'd6:    r = k + (k << 31);
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

// ----- design/rsp_hash.sv -----
`timescale 1ns / 1ps
// rsp_hash: iterative 64-bit key mixer, one mix round per cycle
// depends on rsp_pkg

module rsp_hash (
  input  logic                            clk,
  input  logic                            rst,
  input  rsp_pkg::hash_ctl_t              ctl,
  output logic [rsp_pkg::KEY_W-1:0]       key,
  output logic                            done
);

  logic       busy;
  logic [2:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= busy && (step == rsp_pkg::MIX_LAST);
      if (ctl.load) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == rsp_pkg::MIX_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key <= ctl.seed;
    end else if (busy) begin
      key <= rsp_pkg::mix_step(step, key);
    end
  end

endmodule

// ----- design/rsp_table.sv -----
`timescale 1ns / 1ps
// rsp_table: interval start and owner memories with a one-entry-per-cycle scan
// depends on rsp_pkg

module rsp_table #(
  parameter int DEPTH  = 64,
  parameter int PART_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rsp_pkg::tbl_wr_t    wr,
  input  rsp_pkg::scan_ctl_t  scan,
  output logic [PART_W-1:0]   owner,
  output logic                done
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [rsp_pkg::KEY_W-1:0]   start_mem [DEPTH];
  logic [PART_W-1:0]           owner_mem [DEPTH];

  logic                        busy;
  logic [rsp_pkg::COUNT_W-1:0] cnt;
  logic [rsp_pkg::COUNT_W-1:0] last_addr;
  logic [rsp_pkg::KEY_W-1:0]   key;
  logic                        rd_valid;
  logic                        rd_last;
  logic [rsp_pkg::KEY_W-1:0]   rd_start;
  logic [PART_W-1:0]           rd_owner;

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.slot) < DEPTH)) begin
      start_mem[AW'(wr.slot)] <= wr.start;
      owner_mem[AW'(wr.slot)] <= PART_W'(wr.owner);
    end
    rd_start <= start_mem[AW'(cnt)];
    rd_owner <= owner_mem[AW'(cnt)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      cnt      <= '0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= busy;
      rd_last  <= busy && (cnt == last_addr);
      done     <= rd_valid && rd_last;
      if (scan.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last_addr) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // highest entry whose start is at or below the key wins
  always_ff @(posedge clk) begin
    if (scan.start) begin
      key       <= scan.key;
      last_addr <= scan.count - 1'b1;
      owner     <= '0;
    end else if (rd_valid && (rd_start <= key)) begin
      owner <= rd_owner;
    end
  end

endmodule

// ----- design/random_slice_replica_placer.sv -----
`timescale 1ns / 1ps
// random_slice_replica_placer: top level, sequencer, config registers and result register
// depends on rsp_pkg, rsp_hash and rsp_table

// Item channel: item_valid/item_stall. operation 0 writes one interval table slot
// (entry_index, entry_start, entry_partition).
// operation 1 places the extent at position and yields copies results (0 taken as 1, at
// most min(MAX_COPIES, 8)), each a distinct placed_partition with copy_index counting
// from zero and last on the final one; if the retry index passes 200 an error result (last and error set) ends it.
// Result channel: result_valid/result_stall from a single output register.
// Each try, with n the active interval count, runs a seed step, seven rounds of
// the shared mix unit plus a done step, a scan of the n table entries at one entry
// a cycle through the registered read pipeline, a duplicate check and an emit
// step; a duplicate below the retry limit is skipped and has no emit step.
// item_stall is high from the accept of a placement until its last result is
// loaded; the next item can then be taken while that result waits.
// While the receiver stalls a pending result, the sequencer holds in its emit step.
// Config writes (cfg_write, cfg_index, cfg_data) must be made only while idle; the block itself does not enforce it.
// Reset sets copies and interval_count to 1; the table stays undefined until
// written.

module random_slice_replica_placer #(
  parameter int MAX_INTERVALS  = 64,
  parameter int MAX_COPIES     = 8,
  parameter int PARTITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [rsp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          operation,
  input  logic [rsp_pkg::SLOT_W-1:0]    entry_index,
  input  logic [rsp_pkg::KEY_W-1:0]     entry_start,
  input  logic [rsp_pkg::OWNER_W-1:0]   entry_partition,
  input  logic [rsp_pkg::POS_W-1:0]     position,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [rsp_pkg::OWNER_W-1:0]   placed_partition,
  output logic [2:0]                    copy_index,
  output logic                          last,
  output logic                          error
);

  localparam int CHOSEN_N = (MAX_COPIES < 8) ? MAX_COPIES : 8;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SEED  = 6'b000010,
    S_HASH  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_CHECK = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                        state;
  logic [3:0]                    copies;
  logic [rsp_pkg::COUNT_W-1:0]   interval_count;
  logic [rsp_pkg::KEY_W-1:0]     base;
  logic [rsp_pkg::RETRY_W-1:0]   idx;
  logic [3:0]                    have;
  logic [PARTITION_BITS-1:0]     chosen [CHOSEN_N];
  logic [PARTITION_BITS-1:0]     res_pid;
  logic [2:0]                    res_copy;
  logic                          res_last;
  logic                          res_err;

  logic                          item_take;
  logic                          emit_load;
  logic [3:0]                    want;
  logic [rsp_pkg::COUNT_W-1:0]   n_active;
  logic                          dup;
  logic [rsp_pkg::RETRY_W-1:0]   idx_inc;
  logic [rsp_pkg::KEY_W-1:0]     pos_ext;
  logic [rsp_pkg::KEY_W-1:0]     hash_key;
  logic                          hash_done;
  logic [PARTITION_BITS-1:0]     scan_owner;
  logic                          scan_done;
  rsp_pkg::hash_ctl_t            hash_ctl;
  rsp_pkg::scan_ctl_t            scan_ctl;
  rsp_pkg::tbl_wr_t              tbl_wr;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign emit_load  = (state == S_EMIT) && (!result_valid || !result_stall);
  assign idx_inc    = idx + 1'b1;
  assign pos_ext    = {{(rsp_pkg::KEY_W - rsp_pkg::POS_W){1'b0}}, position};

  always_comb begin
    if (copies == 4'd0) begin
      want = 4'd1;
    end else if (int'(copies) > CHOSEN_N) begin
      want = 4'(CHOSEN_N);
    end else begin
      want = copies;
    end
    if (interval_count == '0) begin
      n_active = rsp_pkg::COUNT_W'(1);
    end else if (int'(interval_count) > MAX_INTERVALS) begin
      n_active = rsp_pkg::COUNT_W'(MAX_INTERVALS);
    end else begin
      n_active = interval_count;
    end
  end

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < CHOSEN_N; k++) begin
      if ((4'(k) < have) && (chosen[k] == scan_owner)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    tbl_wr.en    = item_take && (operation == rsp_pkg::OP_WRITE);
    tbl_wr.slot  = entry_index;
    tbl_wr.start = entry_start;
    tbl_wr.owner = entry_partition;

    hash_ctl.load = (state == S_SEED);
    hash_ctl.seed = base + {{(rsp_pkg::KEY_W - rsp_pkg::RETRY_W){1'b0}}, idx};

    scan_ctl.start = (state == S_HASH) && hash_done;
    scan_ctl.key   = hash_key;
    scan_ctl.count = n_active;
  end

  rsp_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hash_ctl),
    .key  (hash_key),
    .done (hash_done)
  );

  rsp_table #(
    .DEPTH  (MAX_INTERVALS),
    .PART_W (PARTITION_BITS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (tbl_wr),
    .scan  (scan_ctl),
    .owner (scan_owner),
    .done  (scan_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      copies         <= 4'd1;
      interval_count <= rsp_pkg::COUNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        rsp_pkg::REG_COPIES:         copies         <= cfg_data[3:0];
        rsp_pkg::REG_INTERVAL_COUNT: interval_count <= cfg_data;
        default:                     copies         <= copies;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      have  <= 4'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_take && (operation == rsp_pkg::OP_PLACE)) begin
            idx   <= '0;
            have  <= 4'd0;
            state <= S_SEED;
          end
        end
        S_SEED: begin
          state <= S_HASH;
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          idx <= idx_inc;
          if (dup) begin
            state <= (idx_inc > rsp_pkg::RETRY_LIMIT) ? S_EMIT : S_SEED;
          end else begin
            have  <= have + 4'd1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= res_last ? S_IDLE : S_SEED;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // x200 as shifts by 7, 6 and 3, wrapping at 64 bits
  always_ff @(posedge clk) begin
    if (item_take) begin
      base <= (pos_ext << 7) + (pos_ext << 6) + (pos_ext << 3);
    end
    if (state == S_CHECK) begin
      if (dup) begin
        res_pid  <= '0;
        res_copy <= have[2:0];
        res_last <= 1'b1;
        res_err  <= 1'b1;
      end else begin
        for (int k = 0; k < CHOSEN_N; k++) begin
          if (have == 4'(k)) begin
            chosen[k] <= scan_owner;
          end
        end
        res_pid  <= scan_owner;
        res_copy <= have[2:0];
        res_last <= ((have + 4'd1) == want);
        res_err  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      placed_partition <= rsp_pkg::OWNER_W'(res_pid);
      copy_index       <= res_copy;
      last             <= res_last;
      error            <= res_err;
    end
  end

`ifndef ASSERT_OFF
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && error |-> last)
    else $error("error result without last");

  a_hash_in_step: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HASH))
    else $error("hash finished outside its step");

  a_scan_in_step: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == S_SCAN))
    else $error("table scan finished outside its step");

  // past the limit only the remaining distinct copies can still advance the index
  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= (rsp_pkg::RETRY_LIMIT + rsp_pkg::RETRY_W'(8)))
    else $error("retry index beyond limit");

  a_copy_bound: assert property (@(posedge clk) disable iff (rst)
    emit_load && !res_err |-> ({1'b0, res_copy} < want))
    else $error("copy index beyond requested copies");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking testbench for random_slice_replica_placer, with a scoreboard class
// that predicts every placement from its own table copy; depends on rsp_pkg and the rtl

module tb;

  localparam int MAX_SLOTS = 64;
  localparam int MAX_REPLICAS = 8;
  localparam int RETRY_CAP = 200;
  localparam logic [63:0] POS_SCALE = 64'd200;
  localparam logic [55:0] POS_MAX = 56'd46116860184273878;
  localparam int ITEM_TARGET = 330;
  localparam int IDLE_PCT = 32;
  localparam int SETTLE_CYCLES = 80;
  localparam int STUCK_LIMIT = 100000;
  localparam int FIX_COPIES [6] = '{8, 1, 0, 15, 8, 1};
  localparam int FIX_COUNT [6] = '{64, 1, 0, 127, 1, 64};
  localparam int POOLS [4] = '{3, 12, 400, 65536};

  typedef struct packed {
    logic [15:0] pid;
    logic [2:0]  copy;
    logic        last;
    logic        err;
  } replica_t;

  class placement_checker;
    logic [63:0] start_tab [MAX_SLOTS];
    logic [15:0] owner_tab [MAX_SLOTS];
    logic [3:0]  copies_reg;
    logic [6:0]  count_reg;
    replica_t    expected_q [$];
    int unsigned fails, results, retry_errors, placements, writes;

    function new();
      copies_reg = 4'd1;
      count_reg = 7'd1;
      fails = 0;
      results = 0;
      retry_errors = 0;
      placements = 0;
      writes = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] data);
      if (idx == rsp_pkg::REG_COPIES) copies_reg = data[3:0];
      else count_reg = data;
    endfunction

    function logic [63:0] scramble(logic [63:0] k);
      k = ~k + (k << 21);
      k = k ^ (k >> 24);
      k = k + (k << 3) + (k << 8);
      k = k ^ (k >> 14);
      k = k + (k << 2) + (k << 4);
      k = k ^ (k >> 28);
      k = k + (k << 31);
      return k;
    endfunction

    // highest valid slot whose start is not above the key
    function logic [15:0] owner_of(logic [63:0] key);
      int n;
      logic [15:0] o;
      n = (count_reg == 0) ? 1 : ((count_reg > MAX_SLOTS) ? MAX_SLOTS : int'(count_reg));
      o = '0;
      for (int i = 0; i < n; i++) begin
        if (start_tab[i] <= key) o = owner_tab[i];
      end
      return o;
    endfunction

    function void note_item(logic op, logic [5:0] slot, logic [63:0] st, logic [15:0] own,
                            logic [55:0] pos);
      logic [15:0] chosen [MAX_REPLICAS];
      logic [63:0] base;
      logic [15:0] pid;
      logic        dup;
      replica_t    r;
      int          want, have, tries;
      if (op == rsp_pkg::OP_WRITE) begin
        start_tab[slot] = st;
        owner_tab[slot] = own;
        writes++;
        return;
      end
      placements++;
      want = (copies_reg == 0) ? 1 : ((copies_reg > MAX_REPLICAS) ? MAX_REPLICAS
                                                                    : int'(copies_reg));
      base = {8'd0, pos} * POS_SCALE;
      have = 0;
      tries = 0;
      while (have < want) begin
        pid = owner_of(scramble(base + 64'(tries)));
        dup = 1'b0;
        for (int k = 0; k < have; k++) begin
          if (chosen[k] == pid) dup = 1'b1;
        end
        tries++;
        if (dup) begin
          if (tries > RETRY_CAP) begin
            r.pid = '0;
            r.copy = 3'(have);
            r.last = 1'b1;
            r.err = 1'b1;
            expected_q = {expected_q, r};
            return;
          end
        end else begin
          chosen[have] = pid;
          r.pid = pid;
          r.copy = 3'(have);
          r.last = (have + 1 == want);
          r.err = 1'b0;
          expected_q = {expected_q, r};
          have++;
        end
      end
    endfunction

    function void field_diff(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        fails++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_result(replica_t got);
      replica_t want_r;
      results++;
      if (got.err) retry_errors++;
      if (expected_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, actual pid %h copy %0d last %b err %b",
                 $time, got.pid, got.copy, got.last, got.err);
        return;
      end
      want_r = expected_q.pop_front();
      field_diff("placed_partition", want_r.pid, got.pid);
      field_diff("copy_index", 16'(want_r.copy), 16'(got.copy));
      field_diff("last", 16'(want_r.last), 16'(got.last));
      field_diff("error", 16'(want_r.err), 16'(got.err));
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         cfg_write;
  logic                         cfg_index;
  logic [rsp_pkg::CFG_W-1:0]    cfg_data;
  logic                         item_valid;
  logic                         item_stall;
  logic                         operation;
  logic [rsp_pkg::SLOT_W-1:0]   entry_index;
  logic [rsp_pkg::KEY_W-1:0]    entry_start;
  logic [rsp_pkg::OWNER_W-1:0]  entry_partition;
  logic [rsp_pkg::POS_W-1:0]    position;
  logic                         result_valid;
  logic                         result_stall;
  logic [rsp_pkg::OWNER_W-1:0]  placed_partition;
  logic [2:0]                   copy_index;
  logic                         last;
  logic                         error;

  placement_checker sb;
  bit quiet;
  int unsigned items_sent;
  int unsigned settings;
  int unsigned stuck_cycles;

  random_slice_replica_placer u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .operation        (operation),
    .entry_index      (entry_index),
    .entry_start      (entry_start),
    .entry_partition  (entry_partition),
    .position         (position),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .placed_partition (placed_partition),
    .copy_index       (copy_index),
    .last             (last),
    .error            (error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [55:0] rand_pos();
    logic [63:0] w;
    logic [55:0] r;
    w = rand64();
    r = w[55:0];
    if (r > POS_MAX) r = r - POS_MAX - 56'd1;
    return r;
  endfunction

  task automatic send_item(input logic op, input logic [5:0] slot, input logic [63:0] st,
                           input logic [15:0] own, input logic [55:0] pos);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    entry_index <= slot;
    entry_start <= st;
    entry_partition <= own;
    position <= pos;
    do @(posedge clk); while (item_stall);
    sb.note_item(op, slot, st, own, pos);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_entry(input logic [5:0] slot, input logic [63:0] st,
                             input logic [15:0] own);
    send_item(rsp_pkg::OP_WRITE, slot, st, own, rand_pos());
  endtask

  task automatic place_extent(input logic [55:0] pos);
    send_item(rsp_pkg::OP_PLACE, 6'($urandom), rand64(), 16'($urandom), pos);
  endtask

  // hold the sender until every expected result has come, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input int c, input int n);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= rsp_pkg::REG_COPIES;
    cfg_data <= 7'(c);
    @(posedge clk);
    sb.set_reg(rsp_pkg::REG_COPIES, 7'(c));
    @(negedge clk);
    cfg_index <= rsp_pkg::REG_INTERVAL_COUNT;
    cfg_data <= 7'(n);
    @(posedge clk);
    sb.set_reg(rsp_pkg::REG_INTERVAL_COUNT, 7'(n));
    @(negedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // ascending starts over the key space, owners drawn from a pool of the given size
  task automatic load_sorted(input int n, input int pool);
    logic [63:0] step, st;
    logic [15:0] mask;
    step = 64'hFFFF_FFFF_FFFF_FFFF / 64'(n);
    mask = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      st = step * 64'(i) + rand64() % ((step >> 1) + 64'd1);
      if (i == 0 && $urandom_range(0, 1) == 1) st = '0;
      write_entry(6'(i), st, 16'($urandom_range(0, pool - 1)) ^ mask);
    end
  endtask

  always @(negedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_result(replica_t'({placed_partition, copy_index, last, error}));
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int c, n, eff_c, eff_n, cur_pool, k;
    sb = new();
    quiet = 1'b0;
    items_sent = 0;
    settings = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rsp_pkg::REG_COPIES;
    cfg_data = '0;
    item_valid = 1'b0;
    operation = rsp_pkg::OP_WRITE;
    entry_index = '0;
    entry_start = '0;
    entry_partition = '0;
    position = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: one interval, then a key below every start
    write_entry(6'd0, 64'd0, 16'hFFFF);
    place_extent(56'd0);
    place_extent(POS_MAX);
    write_entry(6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h1234);
    place_extent(56'd1);
    place_extent(56'd2);
    // four intervals, three owners: duplicates skipped, then retry limit
    set_regs(3, 4);
    write_entry(6'd0, 64'd0, 16'h0001);
    write_entry(6'd1, 64'h4000_0000_0000_0000, 16'h0002);
    write_entry(6'd2, 64'h8000_0000_0000_0000, 16'h0001);
    write_entry(6'd3, 64'hC000_0000_0000_0000, 16'h0003);
    write_entry(6'd63, 64'd0, 16'h0000);
    repeat (5) place_extent(rand_pos());
    set_regs(8, 4);
    place_extent(rand_pos());
    // unsorted table
    set_regs(2, 4);
    write_entry(6'd1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h00F0);
    place_extent(rand_pos());
    place_extent(POS_MAX);

    // random phases over a fully written table
    load_sorted(MAX_SLOTS, 65536);
    cur_pool = 65536;
    for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
      if (phase < 6) begin
        c = FIX_COPIES[phase];
        n = FIX_COUNT[phase];
      end else begin
        c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
      end
      quiet = (phase >= 6 && phase < 9);
      set_regs(c, n);
      eff_c = (c == 0) ? 1 : ((c > MAX_REPLICAS) ? MAX_REPLICAS : c);
      eff_n = (n == 0) ? 1 : ((n > MAX_SLOTS) ? MAX_SLOTS : n);
      if (phase >= 6 && $urandom_range(0, 2) == 0) begin
        cur_pool = (eff_n <= 16) ? POOLS[$urandom_range(0, 3)] : 65536;
        load_sorted(eff_n, cur_pool);
      end
      k = (eff_c > cur_pool || eff_c > eff_n) ? 3 : $urandom_range(6, 14);
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(0, 9) == 0) write_entry(6'($urandom), rand64(), 16'($urandom));
        place_extent(rand_pos());
      end
    end
    quiet = 1'b0;
    drain();

    $display("covered %0d transfers in: %0d placements, %0d table writes, %0d register settings",
             items_sent, sb.placements, sb.writes, settings);
    $display("checked %0d results, %0d of them retry-limit errors", sb.results, sb.retry_errors);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
